>>> rtl/core/request_frame_receiver_assert.svh
// ----------------------------------------------------------------------------
// Request frame receiver assertion macros
// Concurrent check wrappers for the receiver RTL; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef REQUEST_FRAME_RECEIVER_ASSERT_SVH
`define REQUEST_FRAME_RECEIVER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define RFR_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("request_frame_receiver: check failed");

// next-cycle implication
`define RFR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("request_frame_receiver: check failed");

`else

`define RFR_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define RFR_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

>>> rtl/core/rfr_pkg.sv
// ----------------------------------------------------------------------------
// Request frame receiver package
// Shared types, register indexes, phase and status codes.
// ----------------------------------------------------------------------------
package rfr_pkg;

  // default largest accepted payload length
  localparam int MaxPayloadDefault = 256;

  // frame layout
  localparam int HdrBytes = 18;
  localparam int FlMod    = 255;

  // configuration register indexes
  localparam logic [1:0] RegOwnAddress = 2'd0;
  localparam logic [1:0] RegSyncFirst  = 2'd1;
  localparam logic [1:0] RegSyncSecond = 2'd2;

  localparam logic [15:0] OwnAddressReset = 16'd0;
  localparam logic [7:0]  SyncFirstReset  = 8'd80;
  localparam logic [7:0]  SyncSecondReset = 8'd108;

  // frame phases
  localparam logic [2:0] PhHunt1 = 3'd0;
  localparam logic [2:0] PhHunt2 = 3'd1;
  localparam logic [2:0] PhHdr   = 3'd2;
  localparam logic [2:0] PhPay   = 3'd3;
  localparam logic [2:0] PhCkLo  = 3'd4;
  localparam logic [2:0] PhCkHi  = 3'd5;

  // report status codes
  localparam logic [2:0] StOk         = 3'd0;
  localparam logic [2:0] StAddrMiss   = 3'd1;
  localparam logic [2:0] StBadCheck   = 3'd2;
  localparam logic [2:0] StNotRequest = 3'd3;
  localparam logic [2:0] StTooLong    = 3'd4;
  localparam logic [2:0] StUnconfig   = 3'd5;

  // result kinds
  localparam logic KindPayload = 1'b0;
  localparam logic KindReport  = 1'b1;

  localparam int DataW  = 139;
  localparam int TdataW = 144;

  typedef struct packed {
    logic [15:0] own_address;
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
  } rfr_cfg_t;

  // first member sits in the highest bits: listed from status down
  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] payload_length;
    logic [15:0] param_three;
    logic [15:0] param_two;
    logic [15:0] param_one;
    logic [15:0] command_word;
    logic [15:0] target_address;
    logic [15:0] sender_address;
    logic [15:0] packet_id;
    logic [7:0]  payload_byte;
  } rfr_data_t;

  typedef struct packed {
    logic      kind;
    rfr_data_t data;
  } rfr_result_t;

endpackage

>>> rtl/core/request_frame_receiver.sv
// ----------------------------------------------------------------------------
// Request frame receiver
// Deframes sync-delimited request frames, passes payload bytes through and
// reports each frame with its header and a status.
// ----------------------------------------------------------------------------
// Takes one byte per clock on the slave stream unless the buffer is full, and
// gives at most one word on the master stream for it, from the output
// register. A two-word output buffer keeps the slave side taking bytes while
// a word waits; the slave side stalls only when both entries are full, so
// it takes one byte per cycle as long as the master side drains words.
// Payload bytes come out with tuser low; a frame report comes out with tuser
// high. Write configuration only while no frame is in progress.
// ----------------------------------------------------------------------------
`include "request_frame_receiver_assert.svh"

module request_frame_receiver #(
  parameter int MAX_PAYLOAD = rfr_pkg::MaxPayloadDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration write port
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_addr_i,
  input  logic [15:0]               cfg_wdata_i,
  // byte input stream
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,   // rx_byte
  // result stream
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // tdata from bit 0: payload_byte, packet_id, sender_address, target_address,
  // command_word, param_one, param_two, param_three, payload_length, status
  output logic [rfr_pkg::TdataW-1:0] m_axis_tdata,
  output logic                      m_axis_tuser    // kind
);

  rfr_pkg::rfr_cfg_t    cfg_q;
  rfr_pkg::rfr_result_t res;
  rfr_pkg::rfr_result_t out_q, skid_q;
  logic                 out_vld_q, skid_vld_q;
  logic                 accept, res_valid;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_address <= rfr_pkg::OwnAddressReset;
      cfg_q.sync_first  <= rfr_pkg::SyncFirstReset;
      cfg_q.sync_second <= rfr_pkg::SyncSecondReset;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        rfr_pkg::RegOwnAddress: cfg_q.own_address <= cfg_wdata_i;
        rfr_pkg::RegSyncFirst:  cfg_q.sync_first  <= cfg_wdata_i[7:0];
        rfr_pkg::RegSyncSecond: cfg_q.sync_second <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !skid_vld_q;
  assign accept        = s_axis_tvalid && s_axis_tready;

  rfr_parser #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (accept),
    .byte_i     (s_axis_tdata),
    .cfg_i      (cfg_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  // output register with one skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (out_vld_q && !m_axis_tready) begin
        if (res_valid) begin
          skid_vld_q <= 1'b1;
        end
      end else if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= res_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_vld_q && !m_axis_tready) begin
      if (res_valid) begin
        skid_q <= res;
      end
    end else if (skid_vld_q) begin
      out_q <= skid_q;
    end else if (res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {(rfr_pkg::TdataW - rfr_pkg::DataW)'(0), out_q.data};
  assign m_axis_tuser  = out_q.kind;

  // skid entry is only ever used behind a full output register
  `RFR_ASSERT_NOW(a_skid_behind_out, clk_i, rst_ni, skid_vld_q, out_vld_q)
  // a result arriving at a stalled output lands in the skid entry
  `RFR_ASSERT_NEXT(a_stall_to_skid, clk_i, rst_ni, res_valid && out_vld_q && !m_axis_tready, skid_vld_q)
  // input is refused while the skid entry is full
  `RFR_ASSERT_NOW(a_no_accept_full, clk_i, rst_ni, skid_vld_q, !res_valid)

endmodule

>>> rtl/core/rfr_parser.sv
// ----------------------------------------------------------------------------
// Request frame parser
// Per-byte frame state machine, Fletcher-16 sums and header capture; emits
// at most one result for each accepted byte in the same cycle.
// ----------------------------------------------------------------------------
module rfr_parser #(
  parameter int MAX_PAYLOAD = rfr_pkg::MaxPayloadDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [7:0]          byte_i,
  input  rfr_pkg::rfr_cfg_t   cfg_i,
  output logic                res_valid_o,
  output rfr_pkg::rfr_result_t res_o
);

  logic [2:0]  phase_q, phase_d;
  logic [15:0] idx_q, idx_d;
  logic [7:0]  low_q, low_d, high_q, high_d;
  logic [7:0]  chk_q, chk_d;
  logic [7:0]  hdr_lo_q [8];
  logic [7:0]  hdr_hi_q [8];
  logic [7:0]  hdr_lo_d [8];
  logic [7:0]  hdr_hi_d [8];

  logic [8:0]  add1, add2;
  logic [7:0]  s1, s2, s1_start;
  logic [2:0]  wsel;
  logic [15:0] len_d, cmd_d, len_q;
  logic [16:0] pay_next, pay_end;
  logic        res_valid;
  rfr_pkg::rfr_result_t res;

  // running Fletcher sums, mod 255 by one compare and subtract each
  assign add1     = {1'b0, low_q} + {1'b0, byte_i};
  assign s1       = (add1 >= 9'(rfr_pkg::FlMod)) ? 8'(add1 - 9'(rfr_pkg::FlMod)) : add1[7:0];
  assign add2     = {1'b0, high_q} + {1'b0, s1};
  assign s2       = (add2 >= 9'(rfr_pkg::FlMod)) ? 8'(add2 - 9'(rfr_pkg::FlMod)) : add2[7:0];
  assign s1_start = (byte_i == 8'hff) ? 8'd0 : byte_i;

  // header word slot for this byte position
  assign wsel     = 3'(idx_q[4:1] - 4'd1);
  assign len_d    = {hdr_hi_d[7], hdr_lo_d[7]};
  assign cmd_d    = {hdr_hi_d[3], hdr_lo_d[3]};
  assign len_q    = {hdr_hi_q[7], hdr_lo_q[7]};
  assign pay_next = {1'b0, idx_q} + 17'd1;
  assign pay_end  = 17'(rfr_pkg::HdrBytes) + {1'b0, len_q};

  // header byte lanes
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      hdr_lo_d[k] = hdr_lo_q[k];
      hdr_hi_d[k] = hdr_hi_q[k];
    end
    if (phase_q == rfr_pkg::PhHdr) begin
      if (!idx_q[0]) begin
        hdr_lo_d[wsel] = byte_i;
        hdr_hi_d[wsel] = 8'd0;
      end else begin
        hdr_hi_d[wsel] = byte_i;
      end
    end
  end

  // next phase, sums and result
  always_comb begin
    phase_d   = phase_q;
    idx_d     = idx_q;
    low_d     = low_q;
    high_d    = high_q;
    chk_d     = chk_q;
    res_valid = 1'b0;
    res       = '0;
    res.kind  = rfr_pkg::KindReport;
    res.data.packet_id      = {hdr_hi_d[0], hdr_lo_d[0]};
    res.data.sender_address = {hdr_hi_d[1], hdr_lo_d[1]};
    res.data.target_address = {hdr_hi_d[2], hdr_lo_d[2]};
    res.data.command_word   = cmd_d;
    res.data.param_one      = {hdr_hi_d[4], hdr_lo_d[4]};
    res.data.param_two      = {hdr_hi_d[5], hdr_lo_d[5]};
    res.data.param_three    = {hdr_hi_d[6], hdr_lo_d[6]};
    res.data.payload_length = len_d;
    unique case (phase_q)
      rfr_pkg::PhHunt2: begin
        if (byte_i == cfg_i.sync_second) begin
          low_d   = s1;
          high_d  = s2;
          idx_d   = 16'd2;
          phase_d = rfr_pkg::PhHdr;
        end else if (byte_i == cfg_i.sync_first) begin
          low_d   = s1_start;
          high_d  = s1_start;
          idx_d   = 16'd1;
          phase_d = rfr_pkg::PhHunt2;
        end else begin
          idx_d   = 16'd0;
          phase_d = rfr_pkg::PhHunt1;
        end
      end
      rfr_pkg::PhHdr: begin
        low_d  = s1;
        high_d = s2;
        idx_d  = idx_q + 16'd1;
        if (idx_q >= 16'(rfr_pkg::HdrBytes - 1)) begin
          if (cfg_i.own_address == 16'd0) begin
            res_valid       = 1'b1;
            res.data.status = rfr_pkg::StUnconfig;
          end else if (cmd_d[15]) begin
            res_valid       = 1'b1;
            res.data.status = rfr_pkg::StNotRequest;
          end else if (len_d > 16'(MAX_PAYLOAD)) begin
            res_valid       = 1'b1;
            res.data.status = rfr_pkg::StTooLong;
          end else begin
            phase_d = (len_d != 16'd0) ? rfr_pkg::PhPay : rfr_pkg::PhCkLo;
          end
          if (res_valid) begin
            idx_d   = 16'd0;
            phase_d = rfr_pkg::PhHunt1;
          end
        end
      end
      rfr_pkg::PhPay: begin
        low_d  = s1;
        high_d = s2;
        idx_d  = pay_next[15:0];
        if (pay_next >= pay_end) begin
          phase_d = rfr_pkg::PhCkLo;
        end
        res_valid             = 1'b1;
        res                   = '0;
        res.kind              = rfr_pkg::KindPayload;
        res.data.payload_byte = byte_i;
      end
      rfr_pkg::PhCkLo: begin
        chk_d   = byte_i;
        idx_d   = idx_q + 16'd1;
        phase_d = rfr_pkg::PhCkHi;
      end
      rfr_pkg::PhCkHi: begin
        res_valid = 1'b1;
        if (chk_q != low_q || byte_i != high_q) begin
          res.data.status = rfr_pkg::StBadCheck;
        end else if ({hdr_hi_q[2], hdr_lo_q[2]} != cfg_i.own_address) begin
          res.data.status = rfr_pkg::StAddrMiss;
        end else begin
          res.data.status = rfr_pkg::StOk;
        end
        idx_d   = 16'd0;
        phase_d = rfr_pkg::PhHunt1;
      end
      default: begin
        // first-sync hunt, also for codes that mean nothing
        if (byte_i == cfg_i.sync_first) begin
          low_d   = s1_start;
          high_d  = s1_start;
          idx_d   = 16'd1;
          phase_d = rfr_pkg::PhHunt2;
        end else begin
          idx_d   = 16'd0;
          phase_d = rfr_pkg::PhHunt1;
        end
      end
    endcase
  end

  // advance control state on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= rfr_pkg::PhHunt1;
      idx_q   <= 16'd0;
      low_q   <= 8'd0;
      high_q  <= 8'd0;
      chk_q   <= 8'd0;
    end else if (valid_i) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      low_q   <= low_d;
      high_q  <= high_d;
      chk_q   <= chk_d;
    end
  end

  // header storage, undefined until written
  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      for (int k = 0; k < 8; k++) begin
        hdr_lo_q[k] <= hdr_lo_d[k];
        hdr_hi_q[k] <= hdr_hi_d[k];
      end
    end
  end

  assign res_valid_o = valid_i && res_valid;
  assign res_o       = res;

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// Request frame receiver testbench
// Feeds request frames, broken frames and line noise into the receiver one
// byte per word, predicts every payload word and frame report from the
// accepted bytes, and checks each result word field by field.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxPay        = rfr_pkg::MaxPayloadDefault;
  localparam int RandomBytes   = 980;
  localparam int LatencyCycles = 8;
  localparam int RxHoldCycles  = 300;
  localparam int IdlePercent   = 25;
  localparam int CycleLimit    = 400000;
  localparam int PrintLimit    = 40;

  typedef enum int {FillRandom, FillZero, FillOnes} fill_e;
  typedef enum int {
    FaultNone, FaultCheckLo, FaultCheckHi, FaultTruncate, FaultFlipByte
  } fault_e;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [1:0]         cfg_addr_i;
  logic [15:0]        cfg_wdata_i;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata;   // rx_byte
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  // payload_byte, packet_id, sender_address, target_address, command_word,
  // param_one, param_two, param_three, payload_length, status
  logic [rfr_pkg::TdataW-1:0] m_axis_tdata;
  logic               m_axis_tuser;   // kind

  // register copies as the block should hold them
  logic [15:0] node_addr;
  logic [7:0]  sync_lead;
  logic [7:0]  sync_trail;

  // deframer state
  logic [2:0]  fr_phase;
  logic [15:0] fr_pos;
  logic [15:0] hdr_words [8];
  logic [7:0]  sum_lo;
  logic [7:0]  sum_hi;
  logic [7:0]  check_lo_seen;

  rfr_pkg::rfr_result_t rx_words_due [$];

  int errors;
  int bytes_sent;
  int payload_words;
  int status_seen [6];
  int cycle_count;
  bit idle_on;
  bit hold_req = 1'b0;
  int hold_left;

  request_frame_receiver #(
    .MAX_PAYLOAD(MaxPay)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // advance both Fletcher sums by one byte
  function automatic void add_to_sums(input logic [7:0] b);
    int s1;
    s1 = (int'(sum_lo) + int'(b)) % rfr_pkg::FlMod;
    sum_lo = 8'(s1);
    sum_hi = 8'((int'(sum_hi) + s1) % rfr_pkg::FlMod);
  endfunction

  // step the deframer by one accepted byte; return 1 when a word is due
  function automatic bit deframe_byte(input logic [7:0] b,
                                      output rfr_pkg::rfr_result_t res);
    int pos;
    int w;
    bit rep;
    logic [2:0] st;
    res = '0;
    rep = 1'b0;
    st = rfr_pkg::StOk;
    deframe_byte = 1'b0;
    case (fr_phase)
      rfr_pkg::PhHunt2: begin
        if (b == sync_trail) begin
          add_to_sums(b);
          fr_pos = 16'd2;
          fr_phase = rfr_pkg::PhHdr;
        end else if (b == sync_lead) begin
          // restart the frame on this byte
          sum_lo = 8'd0;
          sum_hi = 8'd0;
          add_to_sums(b);
          fr_pos = 16'd1;
          fr_phase = rfr_pkg::PhHunt2;
        end else begin
          fr_pos = 16'd0;
          fr_phase = rfr_pkg::PhHunt1;
        end
      end
      rfr_pkg::PhHdr: begin
        pos = int'(fr_pos);
        w = ((pos - 2) >> 1) & 7;
        add_to_sums(b);
        if ((pos & 1) == 0) begin
          hdr_words[w] = {8'h00, b};
        end else begin
          hdr_words[w] = hdr_words[w] | {b, 8'h00};
        end
        fr_pos = 16'(pos + 1);
        if (pos + 1 >= rfr_pkg::HdrBytes) begin
          // screen the header in priority order
          if (node_addr == 16'd0) begin
            rep = 1'b1;
            st = rfr_pkg::StUnconfig;
          end else if (hdr_words[3][15]) begin
            rep = 1'b1;
            st = rfr_pkg::StNotRequest;
          end else if (int'(hdr_words[7]) > MaxPay) begin
            rep = 1'b1;
            st = rfr_pkg::StTooLong;
          end else begin
            fr_phase = (hdr_words[7] != 16'd0) ? rfr_pkg::PhPay : rfr_pkg::PhCkLo;
          end
        end
      end
      rfr_pkg::PhPay: begin
        add_to_sums(b);
        fr_pos = fr_pos + 16'd1;
        if (int'(fr_pos) >= rfr_pkg::HdrBytes + int'(hdr_words[7])) begin
          fr_phase = rfr_pkg::PhCkLo;
        end
        res.kind = rfr_pkg::KindPayload;
        res.data.payload_byte = b;
        deframe_byte = 1'b1;
      end
      rfr_pkg::PhCkLo: begin
        check_lo_seen = b;
        fr_pos = fr_pos + 16'd1;
        fr_phase = rfr_pkg::PhCkHi;
      end
      rfr_pkg::PhCkHi: begin
        rep = 1'b1;
        if (check_lo_seen != sum_lo || b != sum_hi) begin
          st = rfr_pkg::StBadCheck;
        end else if (hdr_words[2] != node_addr) begin
          st = rfr_pkg::StAddrMiss;
        end else begin
          st = rfr_pkg::StOk;
        end
      end
      default: begin
        if (b == sync_lead) begin
          sum_lo = 8'd0;
          sum_hi = 8'd0;
          add_to_sums(b);
          fr_pos = 16'd1;
          fr_phase = rfr_pkg::PhHunt2;
        end else begin
          fr_pos = 16'd0;
          fr_phase = rfr_pkg::PhHunt1;
        end
      end
    endcase
    // report the frame and go back to the hunt
    if (rep) begin
      res.kind = rfr_pkg::KindReport;
      res.data.packet_id = hdr_words[0];
      res.data.sender_address = hdr_words[1];
      res.data.target_address = hdr_words[2];
      res.data.command_word = hdr_words[3];
      res.data.param_one = hdr_words[4];
      res.data.param_two = hdr_words[5];
      res.data.param_three = hdr_words[6];
      res.data.payload_length = hdr_words[7];
      res.data.status = st;
      fr_phase = rfr_pkg::PhHunt1;
      fr_pos = 16'd0;
      deframe_byte = 1'b1;
    end
  endfunction

  function automatic logic [15:0] fill_word(input fill_e f);
    case (f)
      FillZero: fill_word = 16'h0000;
      FillOnes: fill_word = 16'hFFFF;
      default:  fill_word = 16'($urandom);
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    if (errors < PrintLimit) begin
      $display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want);
    end
    errors++;
  endtask

  task automatic check_field(input string what, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) flag_mismatch(what, got, want);
  endtask

  // offer one byte, sometimes after an idle gap, and hold it until taken
  task automatic send_byte(input logic [7:0] b);
    int gap;
    rfr_pkg::rfr_result_t res;
    gap = (idle_on && $urandom_range(99) < IdlePercent) ? 1 : 0;
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
    if (deframe_byte(b, res)) begin
      rx_words_due.push_back(res);
      if (res.kind == rfr_pkg::KindReport) status_seen[res.data.status]++;
      else payload_words++;
    end
  endtask

  // build one request frame with a valid checksum, then damage it on request
  task automatic send_frame(input logic [15:0] target, input logic [15:0] cmd,
                            input logic [15:0] len, input fault_e fault,
                            input fill_e fill);
    logic [7:0]  fr [$];
    logic [15:0] words [8];
    int s1;
    int s2;
    int cut;
    int i;
    words[0] = fill_word(fill);
    words[1] = fill_word(fill);
    words[2] = target;
    words[3] = cmd;
    words[4] = fill_word(fill);
    words[5] = fill_word(fill);
    words[6] = fill_word(fill);
    words[7] = len;
    fr.push_back(sync_lead);
    fr.push_back(sync_trail);
    for (i = 0; i < 8; i++) begin
      fr.push_back(words[i][7:0]);
      fr.push_back(words[i][15:8]);
    end
    if (int'(len) <= MaxPay) begin
      for (i = 0; i < int'(len); i++) fr.push_back(8'(fill_word(fill)));
    end
    s1 = 0;
    s2 = 0;
    foreach (fr[k]) begin
      s1 = (s1 + int'(fr[k])) % rfr_pkg::FlMod;
      s2 = (s2 + s1) % rfr_pkg::FlMod;
    end
    fr.push_back(8'(s1));
    fr.push_back(8'(s2));
    case (fault)
      FaultCheckLo: fr[fr.size() - 2] = fr[fr.size() - 2] ^ 8'($urandom_range(255, 1));
      FaultCheckHi: fr[fr.size() - 1] = fr[fr.size() - 1] ^ 8'($urandom_range(255, 1));
      FaultFlipByte: begin
        i = $urandom_range(fr.size() - 3, 2);
        fr[i] = fr[i] ^ 8'($urandom_range(255, 1));
      end
      FaultTruncate: begin
        cut = $urandom_range(fr.size() - 1, 1);
        while (fr.size() > cut) void'(fr.pop_back());
      end
      default: ;
    endcase
    foreach (fr[k]) send_byte(fr[k]);
  endtask

  // drop valid and wait until every due word has come out
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (rx_words_due.size() != 0) @(posedge clk_i);
    repeat (LatencyCycles) @(posedge clk_i);
  endtask

  // bring the block back to the hunt, let it go quiet, then write
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    logic [7:0] filler;
    filler = 8'd0;
    while (filler == sync_lead || filler == sync_trail) filler++;
    while (fr_phase != rfr_pkg::PhHunt1) send_byte(filler);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    case (idx)
      rfr_pkg::RegOwnAddress: node_addr = value;
      rfr_pkg::RegSyncFirst:  sync_lead = value[7:0];
      rfr_pkg::RegSyncSecond: sync_trail = value[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_config(input logic [15:0] own, input logic [7:0] lead,
                              input logic [7:0] trail);
    write_reg(rfr_pkg::RegOwnAddress, own);
    write_reg(rfr_pkg::RegSyncFirst, {8'h00, lead});
    write_reg(rfr_pkg::RegSyncSecond, {8'h00, trail});
  endtask

  // reset sync values, node still unaddressed: broken pair, restart, report
  task automatic test_sync_hunt();
    send_byte(rfr_pkg::SyncFirstReset);
    send_byte(8'h00);
    send_byte(rfr_pkg::SyncFirstReset);
    send_frame(16'h0001, 16'h0001, 16'd0, FaultNone, FillZero);
  endtask

  // at least one frame for each status but unaddressed, header extremes and the longest payload
  task automatic test_status_codes();
    write_config(16'h1234, rfr_pkg::SyncFirstReset, rfr_pkg::SyncSecondReset);
    send_frame(16'h1234, 16'h0000, 16'd0, FaultNone, FillZero);
    send_frame(16'h4321, 16'h7FFF, 16'd3, FaultNone, FillOnes);
    send_frame(16'h1234, 16'h0001, 16'd2, FaultCheckLo, FillRandom);
    send_frame(16'h1234, 16'h0001, 16'd0, FaultCheckHi, FillRandom);
    send_frame(16'h1234, 16'h8000, 16'd1, FaultNone, FillRandom);
    send_frame(16'h1234, 16'hFFFF, 16'hFFFF, FaultNone, FillRandom);
    send_frame(16'h1234, 16'h0002, 16'(MaxPay + 1), FaultNone, FillRandom);
    send_frame(16'h1234, 16'h0002, 16'hFFFF, FaultNone, FillRandom);
    send_frame(16'h1234, 16'h0003, 16'(MaxPay), FaultNone, FillRandom);
  endtask

  // extreme and equal sync values, extreme node addresses
  task automatic test_sync_values();
    write_config(16'hFFFF, 8'h00, 8'hFF);
    send_frame(16'hFFFF, 16'h0004, 16'd4, FaultNone, FillRandom);
    write_config(16'h0001, 8'hFF, 8'h00);
    send_frame(16'h0001, 16'h0005, 16'd5, FaultNone, FillOnes);
    write_config(16'h00A5, 8'hA5, 8'hA5);
    send_byte(8'hA5);
    send_frame(16'h00A5, 16'h0006, 16'd1, FaultNone, FillRandom);
    send_frame(16'h00A5, 16'h0006, 16'd0, FaultNone, FillZero);
  endtask

  // hold off the result side during a long payload so the input stalls
  task automatic test_backpressure();
    write_config(16'h2468, rfr_pkg::SyncFirstReset, rfr_pkg::SyncSecondReset);
    hold_req = 1'b1;
    send_frame(16'h2468, 16'h0010, 16'(MaxPay), FaultNone, FillRandom);
    wait_drained();
  endtask

  // mostly well-formed frames with random content, some noise and damage
  task automatic test_random();
    int first_byte;
    int last_cfg;
    int setting;
    int r;
    int n;
    logic [15:0] target;
    logic [15:0] cmd;
    logic [15:0] len;
    fault_e fault;
    logic [7:0] s;
    first_byte = bytes_sent;
    last_cfg = -1000;
    setting = 0;
    while (bytes_sent - first_byte < RandomBytes) begin
      // quiet stretch with no idling on either side
      idle_on = !((bytes_sent - first_byte >= 350) && (bytes_sent - first_byte < 650));
      if (bytes_sent - last_cfg >= 160) begin
        s = 8'($urandom);
        case (setting % 6)
          0: write_config(16'($urandom_range(65535, 1)), rfr_pkg::SyncFirstReset,
                          rfr_pkg::SyncSecondReset);
          1: write_config(16'hFFFF, 8'h00, 8'hFF);
          2: write_config(16'h0001, 8'hFF, 8'h00);
          3: write_config(16'($urandom_range(65535, 1)), 8'($urandom), 8'($urandom));
          4: write_config(16'h0000, 8'($urandom), 8'($urandom));
          default: write_config(16'($urandom_range(65535, 1)), s, s);
        endcase
        setting++;
        last_cfg = bytes_sent;
      end
      r = $urandom_range(99);
      if (r < 10) begin
        n = $urandom_range(6, 1);
        repeat (n) send_byte(($urandom_range(3) == 0) ? sync_lead : 8'($urandom));
      end else begin
        target = ($urandom_range(99) < 80) ? node_addr : 16'($urandom);
        cmd = ($urandom_range(99) < 10) ? (16'($urandom) | 16'h8000)
                                         : (16'($urandom) & 16'h7FFF);
        r = $urandom_range(99);
        if (r < 65) len = 16'($urandom_range(8));
        else if (r < 88) len = 16'($urandom_range(40, 9));
        else if (r < 94) len = 16'($urandom_range(MaxPay, 41));
        else if (r < 95) len = 16'(MaxPay);
        else len = 16'($urandom_range(65535, MaxPay + 1));
        fault = ($urandom_range(99) < 78) ? FaultNone : fault_e'($urandom_range(4, 1));
        send_frame(target, cmd, len, fault, FillRandom);
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin : stimulus
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_addr_i = rfr_pkg::RegOwnAddress;
    cfg_wdata_i = 16'h0000;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 8'h00;
    node_addr = rfr_pkg::OwnAddressReset;
    sync_lead = rfr_pkg::SyncFirstReset;
    sync_trail = rfr_pkg::SyncSecondReset;
    fr_phase = rfr_pkg::PhHunt1;
    fr_pos = 16'd0;
    foreach (hdr_words[k]) hdr_words[k] = 16'h0000;
    sum_lo = 8'd0;
    sum_hi = 8'd0;
    check_lo_seen = 8'd0;
    errors = 0;
    bytes_sent = 0;
    payload_words = 0;
    idle_on = 1'b1;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_sync_hunt();
    test_status_codes();
    test_sync_values();
    test_backpressure();
    test_random();
    wait_drained();

    $display("covered %0d bytes in %0d cycles, %0d payload words passed through",
             bytes_sent, cycle_count, payload_words);
    $display("frame reports: ok %0d, address miss %0d, bad checksum %0d, %s %0d, %s %0d, %s %0d",
             status_seen[rfr_pkg::StOk], status_seen[rfr_pkg::StAddrMiss],
             status_seen[rfr_pkg::StBadCheck],
             "not request", status_seen[rfr_pkg::StNotRequest],
             "too long", status_seen[rfr_pkg::StTooLong],
             "unaddressed", status_seen[rfr_pkg::StUnconfig]);
    if (errors == 0) begin
      $display("[request_frame_receiver] OK");
    end else begin
      $display("[request_frame_receiver] ERROR");
    end
    $finish;
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin : result_sink
    m_axis_tready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = RxHoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !(idle_on && $urandom_range(99) < IdlePercent);
      end
    end
  end

  // compare each result word with the oldest one due
  always @(posedge clk_i) begin : result_check
    rfr_pkg::rfr_result_t got;
    rfr_pkg::rfr_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind = m_axis_tuser;
      got.data = m_axis_tdata[rfr_pkg::DataW-1:0];
      if (rx_words_due.size() == 0) begin
        flag_mismatch("word with nothing due", {15'd0, got.kind}, 16'h0000);
      end else begin
        want = rx_words_due.pop_front();
        check_field("kind", {15'd0, got.kind}, {15'd0, want.kind});
        check_field("payload_byte", {8'd0, got.data.payload_byte},
                    {8'd0, want.data.payload_byte});
        check_field("packet_id", got.data.packet_id, want.data.packet_id);
        check_field("sender_address", got.data.sender_address, want.data.sender_address);
        check_field("target_address", got.data.target_address, want.data.target_address);
        check_field("command_word", got.data.command_word, want.data.command_word);
        check_field("param_one", got.data.param_one, want.data.param_one);
        check_field("param_two", got.data.param_two, want.data.param_two);
        check_field("param_three", got.data.param_three, want.data.param_three);
        check_field("payload_length", got.data.payload_length, want.data.payload_length);
        check_field("status", {13'd0, got.data.status}, {13'd0, want.data.status});
      end
    end
  end

  // stop a hung run
  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d words still due", cycle_count,
               rx_words_due.size());
      $display("[request_frame_receiver] ERROR");
      $finish;
    end
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/rfr_pkg.sv
rtl/core/rfr_parser.sv
rtl/core/request_frame_receiver.sv
sim/tb.sv
